// ----- src/hce_pkg.sv -----
// ----------------------------------------------------------------------------
// hce_pkg : shared types and constants of the Hill cipher encrypt core
// Letter and key widths, alphabet constants, register codes and the record
// that moves along the row of result cells.
// ----------------------------------------------------------------------------
`default_nettype none

package hce_pkg;

   localparam int LETTER_W   = 5;
   localparam int KEY_SIZE_W = 3;
   localparam int KEY_ROWS   = 4;
   localparam int KEY_ROW_W  = KEY_ROWS * LETTER_W;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam int ALPHABET = 26;
   localparam int PROD_MAX = (2 ** LETTER_W - 1) * (2 ** LETTER_W - 1);

   localparam logic [LETTER_W-1:0] PAD_LETTER = 5'd23;

   localparam logic [2:0] REG_KEY_SIZE  = 3'd0;
   localparam logic [2:0] REG_KEY_ROW_0 = 3'd1;
   localparam logic [2:0] REG_KEY_ROW_1 = 3'd2;
   localparam logic [2:0] REG_KEY_ROW_2 = 3'd3;
   localparam logic [2:0] REG_KEY_ROW_3 = 3'd4;

   typedef logic [LETTER_W-1:0] hce_letter_type;

   typedef struct packed {
      logic           valid;
      hce_letter_type letter;
      logic           last;
   } hce_slot_type;

   typedef struct packed {
      logic load;
      logic shift;
   } hce_chain_ctrl_type;

endpackage

`default_nettype wire

// ----- src/hce_row_cell.sv -----
// ----------------------------------------------------------------------------
// hce_row_cell : one key-matrix row of the encrypt core
// Forms the row-times-block sum, reduces it modulo 26 and holds one result
// slot that takes its neighbour's slot as the row drains.
// ----------------------------------------------------------------------------
`default_nettype none

module hce_row_cell
   import hce_pkg::*;
#(
   parameter int MAX_KEY_SIZE = 4
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    sum_load,
   input  wire logic [MAX_KEY_SIZE-1:0][LETTER_W-1:0]   block_letters,
   input  wire logic [KEY_ROW_W-1:0]                    key_row,
   output hce_letter_type                               cipher,
   input  wire hce_chain_ctrl_type                      chain_ctrl,
   input  wire hce_slot_type                            load_slot,
   input  wire hce_slot_type                            next_slot,
   output hce_slot_type                                 slot
);

   localparam int SUM_W     = $clog2(MAX_KEY_SIZE * PROD_MAX + 1);
   localparam int PROD_W    = 2 * LETTER_W;
   localparam int MOD_STEPS = $clog2(MAX_KEY_SIZE * PROD_MAX / ALPHABET + 1);

   logic [SUM_W-1:0] sum_in;
   logic [SUM_W-1:0] sum_ff;
   hce_slot_type     slot_in;
   hce_slot_type     slot_ff;

   function automatic hce_letter_type mod_alphabet(input logic [SUM_W-1:0] x);
      logic [SUM_W-1:0] r;
      r = x;
      for (int i = MOD_STEPS - 1; i >= 0; i--) begin
         if (r >= SUM_W'(ALPHABET << i)) begin
            r = r - SUM_W'(ALPHABET << i);
         end
      end
      return LETTER_W'(r);
   endfunction

   always_comb begin
      sum_in = '0;
      for (int k = 0; k < MAX_KEY_SIZE; k++) begin
         sum_in = sum_in + SUM_W'(PROD_W'(key_row[k*LETTER_W +: LETTER_W])
                                  * PROD_W'(block_letters[k]));
      end
   end

   always_ff @(posedge clock) begin
      if (sum_load) begin
         sum_ff <= sum_in;
      end
   end

   assign cipher = mod_alphabet(sum_ff);

   always_comb begin
      slot_in = slot_ff;
      if (chain_ctrl.load) begin
         slot_in = load_slot;
      end else if (chain_ctrl.shift) begin
         slot_in = next_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in;
      end
   end

   assign slot = slot_ff;

endmodule

`default_nettype wire

// ----- src/hill_cipher_encrypt_core.sv -----
// ----------------------------------------------------------------------------
// hill_cipher_encrypt_core : streaming Hill cipher encryptor, modulo 26
// Collects plaintext letters into blocks, multiplies each block by the key
// matrix in a row of cells and drains the cipher letters through the row.
//
//   channel  prefix  direction  moves
//   input    req_    in         one plaintext letter and message end flag
//   result   rsp_    out        one cipher letter and last flag
//   config   csr_    in/out     APB register access, key size and key rows
//
// One letter is taken per cycle when ready; a block passes the full block and
// row sum stages, and the cell row drains one a cycle when rsp_ready is high.
// A padded final block gives up to key_size letters from fewer inputs, so
// input stalls while those drain. Reset is synchronous; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module hill_cipher_encrypt_core
   import hce_pkg::*;
#(
   parameter int MAX_KEY_SIZE = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [LETTER_W-1:0]   req_letter,
   input  wire logic                  req_message_end,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [LETTER_W-1:0]        rsp_cipher_letter,
   output logic                       rsp_last,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   localparam int FILL_W = $clog2(MAX_KEY_SIZE);
   localparam int CNT_W  = $clog2(MAX_KEY_SIZE + 1);

   logic [KEY_SIZE_W-1:0]                  key_size_ff;
   logic [KEY_ROW_W-1:0]                   key_row_ff [KEY_ROWS];
   logic                                   csr_write;
   logic [2:0]                             csr_index;

   hce_letter_type                         buf_ff [MAX_KEY_SIZE];
   logic [FILL_W-1:0]                      fill_ff;
   logic [FILL_W-1:0]                      fill_in;

   logic [CNT_W-1:0]                       ks_eff;
   logic [CNT_W-1:0]                       held;
   logic                                   complete;
   logic                                   accept;

   logic                                   s1_v_ff;
   logic [MAX_KEY_SIZE-1:0][LETTER_W-1:0]  blk_ff;
   logic [MAX_KEY_SIZE-1:0][LETTER_W-1:0]  blk_in;
   logic [CNT_W-1:0]                       s1_real_ff;
   logic [CNT_W-1:0]                       s1_ks_ff;
   logic                                   s1_end_ff;
   logic                                   s1_go;

   logic                                   s2_v_ff;
   logic [CNT_W-1:0]                       s2_real_ff;
   logic [CNT_W-1:0]                       s2_ks_ff;
   logic                                   s2_end_ff;
   logic                                   s2_ready;

   logic                                   chain_free;
   hce_chain_ctrl_type                     chain_ctrl;
   hce_letter_type                         cell_cipher [MAX_KEY_SIZE];
   hce_slot_type                           cell_slot   [MAX_KEY_SIZE];
   hce_slot_type                           load_slot   [MAX_KEY_SIZE];
   logic [MAX_KEY_SIZE-1:0]                kept;

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         key_size_ff <= KEY_SIZE_W'(2);
         for (int r = 0; r < KEY_ROWS; r++) begin
            key_row_ff[r] <= '0;
         end
      end else if (csr_write) begin
         case (csr_index)
            REG_KEY_SIZE:  key_size_ff   <= csr_pwdata[KEY_SIZE_W-1:0];
            REG_KEY_ROW_0: key_row_ff[0] <= csr_pwdata[KEY_ROW_W-1:0];
            REG_KEY_ROW_1: key_row_ff[1] <= csr_pwdata[KEY_ROW_W-1:0];
            REG_KEY_ROW_2: key_row_ff[2] <= csr_pwdata[KEY_ROW_W-1:0];
            REG_KEY_ROW_3: key_row_ff[3] <= csr_pwdata[KEY_ROW_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_KEY_SIZE:  csr_prdata = CSR_DATA_W'(key_size_ff);
         REG_KEY_ROW_0: csr_prdata = CSR_DATA_W'(key_row_ff[0]);
         REG_KEY_ROW_1: csr_prdata = CSR_DATA_W'(key_row_ff[1]);
         REG_KEY_ROW_2: csr_prdata = CSR_DATA_W'(key_row_ff[2]);
         REG_KEY_ROW_3: csr_prdata = CSR_DATA_W'(key_row_ff[3]);
         default:       csr_prdata = '0;
      endcase
   end

   // block collection
   always_comb begin
      if (key_size_ff == '0) begin
         ks_eff = CNT_W'(1);
      end else if (32'(key_size_ff) > MAX_KEY_SIZE) begin
         ks_eff = CNT_W'(MAX_KEY_SIZE);
      end else begin
         ks_eff = CNT_W'(key_size_ff);
      end
   end

   assign held      = CNT_W'(fill_ff) + CNT_W'(1);
   assign complete  = (held >= ks_eff) || req_message_end;
   assign s2_ready  = !s2_v_ff || chain_free;
   assign s1_go     = s1_v_ff && s2_ready;
   assign req_ready = !s1_v_ff || s2_ready;
   assign accept    = req_valid && req_ready;
   assign fill_in   = complete ? '0 : FILL_W'(held);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (accept) begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         buf_ff[fill_ff] <= req_letter;
      end
   end

   always_comb begin
      for (int k = 0; k < MAX_KEY_SIZE; k++) begin
         if (CNT_W'(k) >= ks_eff) begin
            blk_in[k] = '0;
         end else if (CNT_W'(k) == CNT_W'(fill_ff)) begin
            blk_in[k] = req_letter;
         end else if (CNT_W'(k) < CNT_W'(fill_ff)) begin
            blk_in[k] = buf_ff[k];
         end else begin
            blk_in[k] = PAD_LETTER;
         end
      end
   end

   // full block stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (accept && complete) begin
         s1_v_ff <= 1'b1;
      end else if (s1_go) begin
         s1_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && complete) begin
         blk_ff     <= blk_in;
         s1_real_ff <= (held < ks_eff) ? held : ks_eff;
         s1_ks_ff   <= ks_eff;
         s1_end_ff  <= req_message_end;
      end
   end

   // row sum stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (s1_go) begin
         s2_v_ff <= 1'b1;
      end else if (chain_ctrl.load) begin
         s2_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         s2_real_ff <= s1_real_ff;
         s2_ks_ff   <= s1_ks_ff;
         s2_end_ff  <= s1_end_ff;
      end
   end

   // drop padded letters from the first pad cipher equal to X
   always_comb begin
      logic stop;
      stop = 1'b0;
      kept = '0;
      for (int j = 0; j < MAX_KEY_SIZE; j++) begin
         if ((CNT_W'(j) < s2_ks_ff) && !stop) begin
            if ((CNT_W'(j) >= s2_real_ff) && (cell_cipher[j] == PAD_LETTER)) begin
               stop = 1'b1;
            end else begin
               kept[j] = 1'b1;
            end
         end
      end
   end

   always_comb begin
      for (int j = 0; j < MAX_KEY_SIZE; j++) begin
         load_slot[j].valid  = kept[j];
         load_slot[j].letter = cell_cipher[j];
         if (j == MAX_KEY_SIZE - 1) begin
            load_slot[j].last = s2_end_ff && kept[j];
         end else begin
            load_slot[j].last = s2_end_ff && kept[j] && !kept[j+1];
         end
      end
   end

   // result row
   assign chain_free       = !cell_slot[1].valid && (!cell_slot[0].valid || rsp_ready);
   assign chain_ctrl.load  = s2_v_ff && chain_free;
   assign chain_ctrl.shift = rsp_valid && rsp_ready;

   for (genvar j = 0; j < MAX_KEY_SIZE; j++) begin : g_cell
      hce_slot_type next_slot;

      if (j == MAX_KEY_SIZE - 1) begin : g_tail
         assign next_slot = '0;
      end else begin : g_body
         assign next_slot = cell_slot[j+1];
      end

      hce_row_cell #(
         .MAX_KEY_SIZE (MAX_KEY_SIZE)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .sum_load      (s1_go),
         .block_letters (blk_ff),
         .key_row       (key_row_ff[j]),
         .cipher        (cell_cipher[j]),
         .chain_ctrl    (chain_ctrl),
         .load_slot     (load_slot[j]),
         .next_slot     (next_slot),
         .slot          (cell_slot[j])
      );
   end

   assign rsp_valid         = cell_slot[0].valid;
   assign rsp_cipher_letter = cell_slot[0].letter;
   assign rsp_last          = cell_slot[0].last;

`ifndef SYNTHESIS
   a_row_prefix : assert property (@(posedge clock) disable iff (reset)
      cell_slot[1].valid |-> cell_slot[0].valid)
      else $error("result row holds a gap at its head");

   a_load_offers : assert property (@(posedge clock) disable iff (reset)
      chain_ctrl.load |=> rsp_valid)
      else $error("loaded block offers no result");

   a_letter_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cipher_letter < LETTER_W'(ALPHABET)))
      else $error("cipher letter outside the alphabet");

   a_block_no_overrun : assert property (@(posedge clock) disable iff (reset)
      (accept && complete) |-> (!s1_v_ff || s1_go))
      else $error("full block overwrites a waiting block");

   a_load_needs_room : assert property (@(posedge clock) disable iff (reset)
      chain_ctrl.load |-> (!cell_slot[0].valid || chain_ctrl.shift))
      else $error("block loaded over an untaken result");
`endif

endmodule

`default_nettype wire
